// ===== sv/bftm_pkg.sv =====
// Shared types, sizes, opcode bytes and status codes for the tape machine stepper.
`default_nettype none

package bftm_pkg;

    localparam int TAPE_CELLS    = 4096;
    localparam int PROGRAM_DEPTH = 4096;

    localparam int TAPE_AW = $clog2(TAPE_CELLS);
    localparam int PROG_AW = $clog2(PROGRAM_DEPTH);
    localparam int PROG_LW = $clog2(PROGRAM_DEPTH + 1);

    localparam int CELL_W = 64;
    localparam int IN_DW  = 16;
    localparam int OUT_DW = 72;

    localparam logic [7:0] OP_RIGHT = 8'h3E;
    localparam logic [7:0] OP_LEFT  = 8'h3C;
    localparam logic [7:0] OP_INC   = 8'h2B;
    localparam logic [7:0] OP_DEC   = 8'h2D;
    localparam logic [7:0] OP_PUT   = 8'h2E;
    localparam logic [7:0] OP_GET   = 8'h2C;
    localparam logic [7:0] OP_JZ    = 8'h5B;
    localparam logic [7:0] OP_JNZ   = 8'h5D;
    localparam logic [7:0] OP_INT   = 8'h69;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BOUND     = 3'd1,
        ST_BADOP     = 3'd2,
        ST_FULL      = 3'd3,
        ST_HALT      = 3'd4,
        ST_UNMATCHED = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SCAN_F_RD,
        S_SCAN_F_CHK,
        S_SCAN_B_RD,
        S_SCAN_B_CHK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic               we;
        logic [TAPE_AW-1:0] addr;
        logic [CELL_W-1:0]  data;
    } tape_wr_t;

    function automatic logic is_opcode(input logic [7:0] c);
        return (c == OP_RIGHT) || (c == OP_LEFT) || (c == OP_INC) || (c == OP_DEC) ||
               (c == OP_PUT) || (c == OP_GET) || (c == OP_JZ) || (c == OP_JNZ) ||
               (c == OP_INT);
    endfunction

endpackage

`default_nettype wire

// ===== sv/bftm_tape_mem.sv =====
// Tape cell memory: one write port and one registered read port.
`default_nettype none

module bftm_tape_mem (
    input  wire logic                            clk,
    input  wire bftm_pkg::tape_wr_t              wr,
    input  wire logic [bftm_pkg::TAPE_AW-1:0]    raddr,
    output      logic [bftm_pkg::CELL_W-1:0]     rdata
);
    import bftm_pkg::*;

    logic [CELL_W-1:0] cells [TAPE_CELLS];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            cells[wr.addr] <= wr.data;
        end
        rdata <= cells[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/bf_tape_machine_stepper_unit.sv =====
// Top level of the tape machine stepper: sequencer, program memory and output register.
// A taken bracket scans the program for its match, one program memory read per byte walked,
// and the scan ends with unmatched status when it runs off the program without finding its match.
// One request is worked at a time; s_tready is high only while the sequencer is idle.
// rst_n is asynchronous and active low; after it the tape memory is cleared one cell per
// cycle, all TAPE_CELLS (4096) cells, and no request is taken during that pass.
`default_nettype none

module bf_tape_machine_stepper_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output      logic                        s_tready,
    // [7:0] code_byte, [15:8] read_char
    input  wire logic [bftm_pkg::IN_DW-1:0]  s_tdata,
    // [0] kind
    input  wire logic                        s_tuser,
    output      logic                        m_tvalid,
    input  wire logic                        m_tready,
    // [0] out_valid, [1] out_kind, [65:2] out_value, [68:66] status, [71:69] zero
    output      logic [bftm_pkg::OUT_DW-1:0] m_tdata
);
    import bftm_pkg::*;

    state_t state_reg, state_next;

    logic [PROG_LW-1:0] pp_reg, pp_next;
    logic [PROG_LW-1:0] len_reg, len_next;
    logic [PROG_LW-1:0] nest_reg, nest_next;
    logic [TAPE_AW-1:0] dp_reg, dp_next;
    logic [TAPE_AW-1:0] clr_reg, clr_next;
    logic [7:0]         rd_reg, rd_next;

    logic               res_valid_reg, res_valid_next;
    logic               res_kind_reg, res_kind_next;
    logic [CELL_W-1:0]  res_value_reg, res_value_next;
    status_t            res_status_reg, res_status_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [OUT_DW-1:0]  m_tdata_reg, m_tdata_next;

    logic [7:0]         prog_mem [PROGRAM_DEPTH];
    logic [7:0]         prog_rdata;
    logic               prog_we;

    tape_wr_t           tape_wr;
    logic [CELL_W-1:0]  cell_rdata;

    logic [7:0] code_byte;
    logic [7:0] read_char;
    logic       in_acc;
    logic       halted;
    logic       out_free;
    logic       cell_zero;
    logic       jz_taken;
    logic       jnz_taken;
    logic [PROG_LW-1:0] pp_inc;
    logic [PROG_LW-1:0] pp_dec;
    logic       f_fail;
    logic       b_fail;
    logic       nest_one;
    logic       f_match;
    logic       b_match;

    assign code_byte = s_tdata[7:0];
    assign read_char = s_tdata[15:8];
    assign s_tready  = (state_reg == S_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign halted    = (pp_reg >= len_reg);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cell_zero = (cell_rdata == '0);
    assign jz_taken  = (prog_rdata == OP_JZ) && cell_zero;
    assign jnz_taken = (prog_rdata == OP_JNZ) && !cell_zero;
    assign pp_inc    = pp_reg + PROG_LW'(1);
    assign pp_dec    = pp_reg - PROG_LW'(1);
    assign f_fail    = (pp_inc >= len_reg);
    assign b_fail    = (pp_reg == '0);
    assign nest_one  = (nest_reg == PROG_LW'(1));
    assign f_match   = (prog_rdata == OP_JNZ) && nest_one;
    assign b_match   = (prog_rdata == OP_JZ) && nest_one;

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Program memory: appends write at the current length; reads follow the next pointer.
    always_ff @(posedge clk)
    begin
        if (prog_we)
        begin
            prog_mem[len_reg[PROG_AW-1:0]] <= code_byte;
        end
        prog_rdata <= prog_mem[pp_next[PROG_AW-1:0]];
    end

    bftm_tape_mem u_tape (
        .clk   (clk),
        .wr    (tape_wr),
        .raddr (dp_reg),
        .rdata (cell_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == TAPE_AW'(TAPE_CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_tuser && !halted)
                    begin
                        state_next = S_EXEC;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_EXEC:
            begin
                if (jz_taken)
                begin
                    state_next = S_SCAN_F_RD;
                end
                else if (jnz_taken)
                begin
                    state_next = S_SCAN_B_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN_F_RD:  state_next = f_fail ? S_DONE : S_SCAN_F_CHK;
            S_SCAN_F_CHK: state_next = f_match ? S_DONE : S_SCAN_F_RD;
            S_SCAN_B_RD:  state_next = b_fail ? S_DONE : S_SCAN_B_CHK;
            S_SCAN_B_CHK: state_next = b_match ? S_DONE : S_SCAN_B_RD;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        pp_next         = pp_reg;
        len_next        = len_reg;
        nest_next       = nest_reg;
        dp_next         = dp_reg;
        clr_next        = clr_reg;
        rd_next         = rd_reg;
        res_valid_next  = res_valid_reg;
        res_kind_next   = res_kind_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        prog_we         = 1'b0;
        tape_wr.we      = 1'b0;
        tape_wr.addr    = dp_reg;
        tape_wr.data    = cell_rdata;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                tape_wr.we   = 1'b1;
                tape_wr.addr = clr_reg;
                tape_wr.data = '0;
                clr_next     = clr_reg + TAPE_AW'(1);
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    res_valid_next  = 1'b0;
                    res_kind_next   = 1'b0;
                    res_value_next  = '0;
                    res_status_next = ST_OK;
                    rd_next         = read_char;
                    if (!s_tuser)
                    begin
                        if (!is_opcode(code_byte))
                        begin
                            res_status_next = ST_BADOP;
                        end
                        else if (len_reg == PROG_LW'(PROGRAM_DEPTH))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            prog_we  = 1'b1;
                            len_next = len_reg + PROG_LW'(1);
                        end
                    end
                    else if (halted)
                    begin
                        res_status_next = ST_HALT;
                    end
                end
            end
            S_EXEC:
            begin
                if (jz_taken || jnz_taken)
                begin
                    nest_next = PROG_LW'(1);
                end
                else
                begin
                    pp_next = pp_inc;
                end
                case (prog_rdata)
                    OP_RIGHT:
                    begin
                        if (dp_reg == TAPE_AW'(TAPE_CELLS - 1))
                        begin
                            res_status_next = ST_BOUND;
                        end
                        else
                        begin
                            dp_next = dp_reg + TAPE_AW'(1);
                        end
                    end
                    OP_LEFT:
                    begin
                        if (dp_reg == '0)
                        begin
                            res_status_next = ST_BOUND;
                        end
                        else
                        begin
                            dp_next = dp_reg - TAPE_AW'(1);
                        end
                    end
                    OP_INC:
                    begin
                        tape_wr.we   = 1'b1;
                        tape_wr.data = cell_rdata + CELL_W'(1);
                    end
                    OP_DEC:
                    begin
                        tape_wr.we   = 1'b1;
                        tape_wr.data = cell_rdata - CELL_W'(1);
                    end
                    OP_GET:
                    begin
                        tape_wr.we   = 1'b1;
                        tape_wr.data = {{(CELL_W - 8){rd_reg[7]}}, rd_reg};
                    end
                    OP_PUT:
                    begin
                        res_valid_next = 1'b1;
                        res_value_next = {{(CELL_W - 8){1'b0}}, cell_rdata[7:0]};
                    end
                    OP_INT:
                    begin
                        res_valid_next = 1'b1;
                        res_kind_next  = 1'b1;
                        res_value_next = cell_rdata;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SCAN_F_RD:
            begin
                if (f_fail)
                begin
                    pp_next         = len_reg;
                    nest_next       = '0;
                    res_status_next = ST_UNMATCHED;
                end
                else
                begin
                    pp_next = pp_inc;
                end
            end
            S_SCAN_F_CHK:
            begin
                if (prog_rdata == OP_JZ)
                begin
                    nest_next = nest_reg + PROG_LW'(1);
                end
                else if (prog_rdata == OP_JNZ)
                begin
                    nest_next = nest_reg - PROG_LW'(1);
                end
                if (f_match)
                begin
                    pp_next = pp_inc;
                end
            end
            S_SCAN_B_RD:
            begin
                if (b_fail)
                begin
                    pp_next         = len_reg;
                    nest_next       = '0;
                    res_status_next = ST_UNMATCHED;
                end
                else
                begin
                    pp_next = pp_dec;
                end
            end
            S_SCAN_B_CHK:
            begin
                if (prog_rdata == OP_JZ)
                begin
                    nest_next = nest_reg - PROG_LW'(1);
                end
                else if (prog_rdata == OP_JNZ)
                begin
                    nest_next = nest_reg + PROG_LW'(1);
                end
                if (b_match)
                begin
                    pp_next = pp_inc;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, res_status_reg, res_value_reg,
                                     res_kind_reg, res_valid_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            pp_reg       <= '0;
            len_reg      <= '0;
            nest_reg     <= '0;
            dp_reg       <= '0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pp_reg       <= pp_next;
            len_reg      <= len_next;
            nest_reg     <= nest_next;
            dp_reg       <= dp_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg         <= rd_next;
        res_valid_reg  <= res_valid_next;
        res_kind_reg   <= res_kind_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
    end

endmodule

`default_nettype wire

// ===== sv/bftm_checker.sv =====
// Port-level checks on the tape machine stepper, attached to the top level by bind.
`default_nettype none

module bftm_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [bftm_pkg::OUT_DW-1:0] m_tdata
);
    import bftm_pkg::*;

    // A result that is held back must not change.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Only one request is worked at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // Without printed output the kind and value fields are zero.
    a_quiet_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> !m_tdata[1] && (m_tdata[65:2] == '0))
        else $error("stray output value");

    // A character output carries the low byte only.
    a_char_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] && !m_tdata[1] |-> (m_tdata[65:10] == '0))
        else $error("character output wider than a byte");

    // Printing steps always complete with ok status.
    a_print_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> (m_tdata[68:66] == ST_OK))
        else $error("printed output with error status");

endmodule

bind bf_tape_machine_stepper_unit bftm_checker u_bftm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
